// ----- sv/fie_pkg.sv -----
// Shared types and constants of the fold instruction executor.
package fie_pkg;

   localparam int REPORT_REGS   = 16;
   localparam int CONTROL_REGS  = 16;
   localparam int TEMP_REGS     = 16;
   localparam int LOCAL_REGS    = 16;
   localparam int IMPLICIT_REGS = 6;
   localparam int PRIM_SLOTS    = 16;
   localparam int PRIM_RTT      = 13;
   localparam int PRIM_UNUSED   = 15;
   localparam logic [63:0] FRAC_DENOM  = 64'd10;
   localparam logic [63:0] ALL_ONES_32 = 64'h0000_0000_FFFF_FFFF;
   // ceil(2^67 / 10): x / 10 == (x * RECIP_TEN) >> 67 for any 64-bit x
   localparam logic [63:0] RECIP_TEN   = 64'hCCCC_CCCC_CCCC_CCCD;
   localparam int DIV_STEPS = 64;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_DIV = 4'd1, OP_EQ = 4'd2, OP_EWMA = 4'd3, OP_GT = 4'd4,
      OP_LT = 4'd5, OP_MAX = 4'd6, OP_MIN = 4'd7, OP_MUL = 4'd8, OP_SUB = 4'd9,
      OP_MAXWRAP = 4'd10, OP_IF = 4'd11, OP_NOTIF = 4'd12, OP_BIND = 4'd13
   } opcode_type;

   typedef enum logic [2:0] {
      CLS_IMM = 3'd0, CLS_REPORT = 3'd1, CLS_CONTROL = 3'd2, CLS_TEMP = 3'd3,
      CLS_LOCAL = 3'd4, CLS_IMPLICIT = 3'd5, CLS_PRIM = 3'd6
   } reg_class_type;

   typedef enum logic [1:0] {
      STS_OK = 2'd0, STS_OVERFLOW = 2'd1, STS_UNDERFLOW = 2'd2, STS_DIV_ZERO = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_LEFT = 2'd0, SEL_RIGHT = 2'd1, SEL_DEST = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_L, ST_RD_R, ST_RD_D, ST_MUL, ST_DIV_INIT, ST_DIV, ST_FIN
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       mul_clr;
      logic       mul_en;
      logic [3:0] mul_step;
      logic       div_init;
      logic       div_en;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_mul;
      logic is_ewma;
      logic is_div;
      logic r_zero;
      logic d_zero;
   } stat_type;

endpackage

// ----- sv/fie_ctrl.sv -----
// Sequencer of the fold instruction executor: operand reads, multiply and divide steps.
module fie_ctrl
   import fie_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_RD_L;
            end
         end
         ST_RD_L: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_LEFT;
            state_in   = stat.is_load ? ST_FIN : ST_RD_R;
         end
         ST_RD_R: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_RIGHT;
            state_in   = ST_RD_D;
         end
         ST_RD_D: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = SEL_DEST;
            cmd.mul_clr = 1'b1;
            cnt_in      = '0;
            if (stat.is_mul || stat.is_ewma) begin
               state_in = ST_MUL;
            end else if (stat.is_div && !stat.r_zero) begin
               state_in = ST_DIV_INIT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            // ewma: six numerator steps, then four steps of the multiply by 1/10
            cmd.mul_en   = 1'b1;
            cmd.mul_step = cnt_ff[3:0];
            cnt_in       = cnt_ff + 6'd1;
            if (stat.is_mul && cnt_ff == 6'd2) begin
               state_in = ST_FIN;
            end else if (stat.is_ewma && (stat.d_zero || cnt_ff == 6'd9)) begin
               state_in = ST_FIN;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- sv/fie_dpath.sv -----
// Register files, operand fetch, shared multiplier, serial divider and result logic.
module fie_dpath
   import fie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_type,
   input  logic [3:0]  req_opcode,
   input  logic [2:0]  req_dst_class,
   input  logic [7:0]  req_dst_index,
   input  logic [2:0]  req_left_class,
   input  logic [31:0] req_left_operand,
   input  logic [2:0]  req_right_class,
   input  logic [31:0] req_right_operand,
   input  logic [3:0]  req_prim_index,
   input  logic [63:0] req_prim_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_result_value,
   output logic        rsp_wrote
);

   localparam int RPW = (REPORT_REGS   > 1) ? $clog2(REPORT_REGS)   : 1;
   localparam int CTW = (CONTROL_REGS  > 1) ? $clog2(CONTROL_REGS)  : 1;
   localparam int TPW = (TEMP_REGS     > 1) ? $clog2(TEMP_REGS)     : 1;
   localparam int LCW = (LOCAL_REGS    > 1) ? $clog2(LOCAL_REGS)    : 1;
   localparam int IMW = $clog2(IMPLICIT_REGS);
   localparam int PRW = $clog2(PRIM_SLOTS);

   logic [63:0] rpt_ff [REPORT_REGS];
   logic [63:0] ctl_ff [CONTROL_REGS];
   logic [63:0] tmp_ff [TEMP_REGS];
   logic [63:0] loc_ff [LOCAL_REGS];
   logic [63:0] imp_ff [IMPLICIT_REGS];
   logic [63:0] prim_ff [PRIM_SLOTS];

   // latched request
   logic        type_ff;
   logic [3:0]  op_ff;
   logic [2:0]  dc_ff, lc_ff, rc_ff;
   logic [7:0]  di_ff;
   logic [31:0] lo_ff, ro_ff;
   logic [3:0]  pi_ff;
   logic [63:0] pv_ff;

   logic [63:0]  l_ff, r_ff, d_ff, acc_ff, rem_ff, quo_ff, dvs_ff;
   logic [127:0] prod_ff;
   logic         valid_ff, wrote_ff;
   logic [1:0]   status_ff;
   logic [63:0]  value_ff;

   // operand fetch
   logic [2:0]  rd_cls;
   logic [31:0] rd_idx;
   logic [63:0] rd_data;

   always_comb begin
      case (cmd.rd_sel)
         SEL_LEFT:  begin rd_cls = lc_ff; rd_idx = lo_ff; end
         SEL_RIGHT: begin rd_cls = rc_ff; rd_idx = ro_ff; end
         default:   begin rd_cls = dc_ff; rd_idx = {24'd0, di_ff}; end
      endcase
      rd_data = '0;
      case (rd_cls)
         CLS_IMM: rd_data = {32'd0, rd_idx};
         CLS_REPORT:
            if (rd_idx < 32'(REPORT_REGS)) rd_data = rpt_ff[rd_idx[RPW-1:0]];
         CLS_CONTROL:
            if (rd_idx < 32'(CONTROL_REGS)) rd_data = ctl_ff[rd_idx[CTW-1:0]];
         CLS_TEMP:
            if (rd_idx < 32'(TEMP_REGS)) rd_data = tmp_ff[rd_idx[TPW-1:0]];
         CLS_LOCAL:
            if (rd_idx < 32'(LOCAL_REGS)) rd_data = loc_ff[rd_idx[LCW-1:0]];
         CLS_IMPLICIT:
            if (rd_idx < 32'(IMPLICIT_REGS)) rd_data = imp_ff[rd_idx[IMW-1:0]];
         CLS_PRIM: begin
            if (rd_idx < 32'(PRIM_SLOTS) && rd_idx != 32'(PRIM_UNUSED)) begin
               rd_data = prim_ff[rd_idx[PRW-1:0]];
               if (rd_idx == 32'(PRIM_RTT) && rd_data == 64'd0) rd_data = ALL_ONES_32;
            end
         end
         default: rd_data = '0;
      endcase
   end

   // multiply step: one 32x32 partial product per cycle
   // steps 0-5 build the product mod 2^64, steps 6-9 the full 128-bit x * 1/10
   logic [63:0]  ma, mb, pp, pp_sh;
   logic [127:0] pp_wide;
   always_comb begin
      if (cmd.mul_step >= 4'd6) begin
         ma = acc_ff;
         mb = RECIP_TEN;
      end else begin
         ma = (cmd.mul_step < 4'd3) ? l_ff : (FRAC_DENOM - l_ff);
         mb = (cmd.mul_step < 4'd3 && op_ff == OP_EWMA) ? d_ff : r_ff;
      end
      case (cmd.mul_step)
         4'd0, 4'd3, 4'd6: begin
            pp      = ma[31:0] * mb[31:0];
            pp_sh   = pp;
            pp_wide = {64'd0, pp};
         end
         4'd1, 4'd4, 4'd7: begin
            pp      = ma[31:0] * mb[63:32];
            pp_sh   = {pp[31:0], 32'd0};
            pp_wide = {32'd0, pp, 32'd0};
         end
         4'd9: begin
            pp      = ma[63:32] * mb[63:32];
            pp_sh   = '0;
            pp_wide = {pp, 64'd0};
         end
         default: begin
            pp      = ma[63:32] * mb[31:0];
            pp_sh   = {pp[31:0], 32'd0};
            pp_wide = {32'd0, pp, 32'd0};
         end
      endcase
   end

   // restoring divide step
   logic [64:0] shifted, trial;
   assign shifted = {rem_ff, quo_ff[63]};
   assign trial   = shifted - {1'b0, dvs_ff};

   // wrap-aware max
   logic [31:0] a32, b32, fwd, back;
   logic [63:0] wmax;
   assign a32  = l_ff[31:0];
   assign b32  = r_ff[31:0];
   assign fwd  = (b32 > a32) ? (b32 - a32) : (~a32 + b32);
   assign back = (a32 > b32) ? (a32 - b32) : (~b32 + a32);
   always_comb begin
      if (l_ff == 64'd0)      wmax = r_ff;
      else if (r_ff == 64'd0) wmax = l_ff;
      else if (back < fwd)    wmax = {32'd0, a32};
      else                    wmax = {32'd0, b32};
   end

   // final result
   logic [63:0] sum, diff, v_calc, v_out;
   logic [1:0]  sts;
   logic        doit, dst_ok, do_wr;
   assign sum  = l_ff + r_ff;
   assign diff = l_ff - r_ff;

   always_comb begin
      v_calc = '0;
      sts    = STS_OK;
      doit   = 1'b1;
      case (op_ff)
         OP_ADD:     begin v_calc = sum; if (sum < l_ff) sts = STS_OVERFLOW; end
         OP_DIV:     begin
            if (r_ff == 64'd0) sts = STS_DIV_ZERO;
            else v_calc = quo_ff;
         end
         OP_EQ:      v_calc = {63'd0, l_ff == r_ff};
         OP_EWMA:    v_calc = (d_ff == 64'd0) ? r_ff : {3'd0, prod_ff[127:67]};
         OP_GT:      v_calc = {63'd0, l_ff > r_ff};
         OP_LT:      v_calc = {63'd0, l_ff < r_ff};
         OP_MAX:     v_calc = (l_ff > r_ff) ? l_ff : r_ff;
         OP_MIN:     v_calc = (l_ff < r_ff) ? l_ff : r_ff;
         OP_MUL:     begin
            v_calc = acc_ff;
            if (acc_ff < l_ff && r_ff != 64'd0) sts = STS_OVERFLOW;
         end
         OP_SUB:     begin v_calc = diff; if (diff > l_ff) sts = STS_UNDERFLOW; end
         OP_MAXWRAP: v_calc = wmax;
         OP_IF:      begin doit = (l_ff != 64'd0); v_calc = r_ff; end
         OP_NOTIF:   begin doit = (l_ff == 64'd0); v_calc = r_ff; end
         OP_BIND:    v_calc = r_ff;
         default:    doit = 1'b0;
      endcase
      case (dc_ff)
         CLS_REPORT:   dst_ok = (di_ff < 8'(REPORT_REGS)) || (REPORT_REGS > 255);
         CLS_CONTROL:  dst_ok = (di_ff < 8'(CONTROL_REGS)) || (CONTROL_REGS > 255);
         CLS_TEMP:     dst_ok = (di_ff < 8'(TEMP_REGS)) || (TEMP_REGS > 255);
         CLS_LOCAL:    dst_ok = (di_ff < 8'(LOCAL_REGS)) || (LOCAL_REGS > 255);
         CLS_IMPLICIT: dst_ok = (di_ff < 8'(IMPLICIT_REGS));
         default:      dst_ok = 1'b0;
      endcase
      if (sts != STS_OK || !doit) begin
         v_out = '0;
         do_wr = 1'b0;
      end else begin
         v_out = v_calc;
         do_wr = dst_ok;
      end
   end

   assign stat.is_load = ~type_ff;
   assign stat.is_mul  = (op_ff == OP_MUL);
   assign stat.is_ewma = (op_ff == OP_EWMA);
   assign stat.is_div  = (op_ff == OP_DIV);
   assign stat.r_zero  = (r_ff == 64'd0);
   assign stat.d_zero  = (d_ff == 64'd0);

   // payload, operand, multiply, divide and result registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         op_ff   <= req_opcode;
         dc_ff   <= req_dst_class;
         di_ff   <= req_dst_index;
         lc_ff   <= req_left_class;
         lo_ff   <= req_left_operand;
         rc_ff   <= req_right_class;
         ro_ff   <= req_right_operand;
         pi_ff   <= req_prim_index;
         pv_ff   <= req_prim_value;
      end
      if (cmd.rd_en) begin
         case (cmd.rd_sel)
            SEL_LEFT:  l_ff <= rd_data;
            SEL_RIGHT: r_ff <= rd_data;
            default:   d_ff <= rd_data;
         endcase
      end
      if (cmd.mul_clr) begin
         acc_ff  <= '0;
         prod_ff <= '0;
      end else if (cmd.mul_en) begin
         if (cmd.mul_step < 4'd6) acc_ff <= acc_ff + pp_sh;
         else                     prod_ff <= prod_ff + pp_wide;
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= l_ff;
         dvs_ff <= r_ff;
      end else if (cmd.div_en) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         if (!type_ff) begin
            status_ff <= STS_OK;
            value_ff  <= pv_ff;
            wrote_ff  <= 1'b0;
         end else begin
            status_ff <= sts;
            value_ff  <= v_out;
            wrote_ff  <= do_wr;
         end
      end
   end

   // register files, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < REPORT_REGS; i++)   rpt_ff[i]  <= '0;
         for (int i = 0; i < CONTROL_REGS; i++)  ctl_ff[i]  <= '0;
         for (int i = 0; i < TEMP_REGS; i++)     tmp_ff[i]  <= '0;
         for (int i = 0; i < LOCAL_REGS; i++)    loc_ff[i]  <= '0;
         for (int i = 0; i < IMPLICIT_REGS; i++) imp_ff[i]  <= '0;
         for (int i = 0; i < PRIM_SLOTS; i++)    prim_ff[i] <= '0;
      end else begin
         valid_ff <= cmd.finish;
         if (cmd.finish && !type_ff) prim_ff[pi_ff[PRW-1:0]] <= pv_ff;
         if (cmd.finish && type_ff && do_wr) begin
            case (dc_ff)
               CLS_REPORT:   rpt_ff[di_ff[RPW-1:0]] <= v_out;
               CLS_CONTROL:  ctl_ff[di_ff[CTW-1:0]] <= v_out;
               CLS_TEMP:     tmp_ff[di_ff[TPW-1:0]] <= v_out;
               CLS_LOCAL:    loc_ff[di_ff[LCW-1:0]] <= v_out;
               CLS_IMPLICIT: imp_ff[di_ff[IMW-1:0]] <= v_out;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;
   assign rsp_wrote        = wrote_ff;

endmodule

// ----- sv/fold_instruction_executor_unit.sv -----
// Top level of the fold instruction executor.
// Use: raise start with the request fields on the req_ ports; the item is
// transferred at a clock edge where start is high and busy is low. busy stays
// high until the cycle in which the result is shown. One item at a time.
// Each item gives one result on the rsp_ ports, marked by rsp_valid for one
// cycle; the receiver cannot stall, so it must take the transfer then.
// The sequencer reads the left, right and destination operands through one
// port, then runs the steps of the operation:
//   primitive load: left operand read, then the result
//   plain operations, divide by zero: the three operand reads, then the result
//   multiply: three 32x32 partial products on one multiplier
//   divide: an init step, then 64 steps of the one-bit-per-cycle divider
//   ewma: six partial products, four more to multiply by 1/10;
//         it stops after the first step when the old destination value is zero
// A new item may be transferred at the edge that ends the rsp_valid cycle.
// Reset clears all register files, primitive slots and the sequencer.
module fold_instruction_executor_unit
   import fie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [3:0]  req_opcode,
   input  logic [2:0]  req_dst_class,
   input  logic [7:0]  req_dst_index,
   input  logic [2:0]  req_left_class,
   input  logic [31:0] req_left_operand,
   input  logic [2:0]  req_right_class,
   input  logic [31:0] req_right_operand,
   input  logic [3:0]  req_prim_index,
   input  logic [63:0] req_prim_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_result_value,
   output logic        rsp_wrote
);

   cmd_type  cmd;
   stat_type stat;

   fie_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fie_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_opcode        (req_opcode),
      .req_dst_class     (req_dst_class),
      .req_dst_index     (req_dst_index),
      .req_left_class    (req_left_class),
      .req_left_operand  (req_left_operand),
      .req_right_class   (req_right_class),
      .req_right_operand (req_right_operand),
      .req_prim_index    (req_prim_index),
      .req_prim_value    (req_prim_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_value  (rsp_result_value),
      .rsp_wrote         (rsp_wrote)
   );

endmodule

// ----- tb/fold_instruction_executor_unit_tb.sv -----
// Self-checking testbench of the fold instruction executor unit.
`timescale 1ns / 1ps

module fold_instruction_executor_unit_tb
   import fie_pkg::*;
();

   typedef struct {
      logic        is_instr;
      logic [3:0]  opcode;
      logic [2:0]  dst_class;
      logic [7:0]  dst_index;
      logic [2:0]  left_class;
      logic [31:0] left_operand;
      logic [2:0]  right_class;
      logic [31:0] right_operand;
      logic [3:0]  prim_index;
      logic [63:0] prim_value;
   } instr_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] value;
      logic        wrote;
   } outcome_type;

   localparam int N_RANDOM = 500;
   localparam longint CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = 1'b0;
   logic [3:0]  req_opcode = '0;
   logic [2:0]  req_dst_class = '0;
   logic [7:0]  req_dst_index = '0;
   logic [2:0]  req_left_class = '0;
   logic [31:0] req_left_operand = '0;
   logic [2:0]  req_right_class = '0;
   logic [31:0] req_right_operand = '0;
   logic [3:0]  req_prim_index = '0;
   logic [63:0] req_prim_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_result_value;
   logic        rsp_wrote;

   // shadow register files
   logic [63:0] sh_report [REPORT_REGS];
   logic [63:0] sh_control [CONTROL_REGS];
   logic [63:0] sh_temp [TEMP_REGS];
   logic [63:0] sh_local [LOCAL_REGS];
   logic [63:0] sh_implicit [IMPLICIT_REGS];
   logic [63:0] sh_prim [PRIM_SLOTS];

   instr_item_type pending_items[$];
   outcome_type    expected_outcomes[$];
   int             error_count = 0;
   longint         cycle_count = 0;
   bit             quiet_phase = 1'b0;
   int             drive_gap = 0;
   logic           accepted = 1'b0;

   always #5 clock = ~clock;

   fold_instruction_executor_unit i_dut (.*);

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
   endtask

   function automatic logic [63:0] fetch_shadow(input logic [2:0] cls,
                                                input logic [31:0] idx);
      case (cls)
         CLS_IMM:      return {32'd0, idx};
         CLS_REPORT:   return idx < REPORT_REGS ? sh_report[idx] : 64'd0;
         CLS_CONTROL:  return idx < CONTROL_REGS ? sh_control[idx] : 64'd0;
         CLS_TEMP:     return idx < TEMP_REGS ? sh_temp[idx] : 64'd0;
         CLS_LOCAL:    return idx < LOCAL_REGS ? sh_local[idx] : 64'd0;
         CLS_IMPLICIT: return idx < IMPLICIT_REGS ? sh_implicit[idx] : 64'd0;
         CLS_PRIM: begin
            if (idx >= PRIM_SLOTS || idx == PRIM_UNUSED) return 64'd0;
            if (idx == PRIM_RTT && sh_prim[idx] == 0) return ALL_ONES_32;
            return sh_prim[idx];
         end
         default:      return 64'd0;
      endcase
   endfunction

   function automatic logic store_shadow(input logic [2:0] cls, input logic [7:0] idx,
                                         input logic [63:0] v);
      case (cls)
         CLS_REPORT:   if (idx < REPORT_REGS) begin sh_report[idx] = v; return 1'b1; end
         CLS_CONTROL:  if (idx < CONTROL_REGS) begin sh_control[idx] = v; return 1'b1; end
         CLS_TEMP:     if (idx < TEMP_REGS) begin sh_temp[idx] = v; return 1'b1; end
         CLS_LOCAL:    if (idx < LOCAL_REGS) begin sh_local[idx] = v; return 1'b1; end
         CLS_IMPLICIT: if (idx < IMPLICIT_REGS) begin sh_implicit[idx] = v; return 1'b1; end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic logic [31:0] ring_dist(input logic [31:0] from, input logic [31:0] to);
      if (to > from) return to - from;
      return (32'hFFFF_FFFF - from) + to;
   endfunction

   function automatic outcome_type execute_item(input instr_item_type it);
      outcome_type o;
      logic [63:0] l, r, v, d;
      logic ok;
      o = '{STS_OK, 64'd0, 1'b0};
      if (!it.is_instr) begin
         sh_prim[it.prim_index] = it.prim_value;
         o.value = it.prim_value;
         return o;
      end
      l = fetch_shadow(it.left_class, it.left_operand);
      r = fetch_shadow(it.right_class, it.right_operand);
      v = 64'd0;
      ok = 1'b1;
      case (it.opcode)
         OP_ADD:  begin v = l + r; if (v < l) o.status = STS_OVERFLOW; end
         OP_DIV:  if (r == 0) o.status = STS_DIV_ZERO; else v = l / r;
         OP_EQ:   v = (l == r);
         OP_EWMA: begin
            d = fetch_shadow(it.dst_class, {24'd0, it.dst_index});
            v = (d == 0) ? r : (l * d + (FRAC_DENOM - l) * r) / FRAC_DENOM;
         end
         OP_GT:   v = (l > r);
         OP_LT:   v = (l < r);
         OP_MAX:  v = (l > r) ? l : r;
         OP_MIN:  v = (l < r) ? l : r;
         OP_MUL:  begin v = l * r; if (v < l && r > 0) o.status = STS_OVERFLOW; end
         OP_SUB:  begin v = l - r; if (v > l) o.status = STS_UNDERFLOW; end
         OP_MAXWRAP: begin
            if (l == 0) v = r;
            else if (r == 0) v = l;
            else if (ring_dist(r[31:0], l[31:0]) < ring_dist(l[31:0], r[31:0]))
               v = {32'd0, l[31:0]};
            else v = {32'd0, r[31:0]};
         end
         OP_IF:    begin ok = (l != 0); v = r; end
         OP_NOTIF: begin ok = (l == 0); v = r; end
         OP_BIND:  v = r;
         default:  ok = 1'b0;
      endcase
      if (o.status != STS_OK || !ok) o.value = 64'd0;
      else begin
         o.value = v;
         o.wrote = store_shadow(it.dst_class, it.dst_index, v);
      end
      return o;
   endfunction

   function automatic logic [31:0] pick_operand(input logic [2:0] cls);
      int k;
      k = $urandom_range(0, 9);
      if (cls == CLS_IMM) begin
         case (k)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(0, 12);
            default: return $urandom;
         endcase
      end
      if (k == 0) return $urandom;
      if (k == 1) return $urandom_range(16, 300);
      return $urandom_range(0, 15);
   endfunction

   function automatic instr_item_type random_item();
      instr_item_type it;
      it.is_instr = ($urandom_range(0, 5) != 0);
      it.opcode = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(14, 15))
                                               : 4'($urandom_range(0, 13));
      // keep divides and ewma sparse, they are slow
      if ((it.opcode == OP_DIV || it.opcode == OP_EWMA) && $urandom_range(0, 2) != 0)
         it.opcode = OP_BIND;
      it.dst_class = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7) | 0)
                                                 : 3'($urandom_range(1, 5));
      it.dst_index = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      it.left_class = 3'($urandom_range(0, 7));
      it.left_operand = pick_operand(it.left_class);
      it.right_class = 3'($urandom_range(0, 7));
      it.right_operand = pick_operand(it.right_class);
      it.prim_index = 4'($urandom);
      it.prim_value = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
      return it;
   endfunction

   function automatic instr_item_type make_instr(input logic [3:0] op, input logic [2:0] dc,
                                                 input logic [7:0] di, input logic [2:0] lc,
                                                 input logic [31:0] lv, input logic [2:0] rc,
                                                 input logic [31:0] rv);
      instr_item_type it;
      it = '{1'b1, op, dc, di, lc, lv, rc, rv, 4'd0, 64'd0};
      return it;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      accepted <= !reset && start && !busy;
   end

   // driver
   always @(negedge clock) begin
      instr_item_type it;
      if (!reset) begin
         if (start && !accepted) begin
            // hold the request
         end else if (drive_gap > 0) begin
            drive_gap <= drive_gap - 1;
            start <= 1'b0;
         end else if (pending_items.size() > 0 && !(start && accepted &&
                      !quiet_phase && $urandom_range(0, 3) == 0)) begin
            it = pending_items.pop_front();
            expected_outcomes.push_back(execute_item(it));
            start <= 1'b1;
            req_type <= it.is_instr;
            req_opcode <= it.opcode;
            req_dst_class <= it.dst_class;
            req_dst_index <= it.dst_index;
            req_left_class <= it.left_class;
            req_left_operand <= it.left_operand;
            req_right_class <= it.right_class;
            req_right_operand <= it.right_operand;
            req_prim_index <= it.prim_index;
            req_prim_value <= it.prim_value;
            if (!quiet_phase && $urandom_range(0, 4) == 0)
               drive_gap <= $urandom_range(1, 4);
         end else begin
            start <= 1'b0;
            if (start && accepted && !quiet_phase && pending_items.size() > 0)
               drive_gap <= $urandom_range(0, 3);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_result_value, 64'd0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_result_value !== want.value)
               report_mismatch("result_value", rsp_result_value, want.value);
            if (rsp_wrote !== want.wrote) report_mismatch("wrote", rsp_wrote, want.wrote);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("** fold_instruction_executor_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int n;
      instr_item_type it;
      foreach (sh_report[i]) sh_report[i] = '0;
      foreach (sh_control[i]) sh_control[i] = '0;
      foreach (sh_temp[i]) sh_temp[i] = '0;
      foreach (sh_local[i]) sh_local[i] = '0;
      foreach (sh_implicit[i]) sh_implicit[i] = '0;
      foreach (sh_prim[i]) sh_prim[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      pending_items.push_back(make_instr(OP_BIND, CLS_TEMP, 0, CLS_PRIM, PRIM_RTT,
                                         CLS_PRIM, PRIM_RTT));
      it = '{1'b0, 4'd0, 3'd0, 8'd0, 3'd0, 32'd0, 3'd0, 32'd0, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF};
      pending_items.push_back(it);
      it.prim_index = 4'd1;
      pending_items.push_back(it);
      pending_items.push_back(make_instr(OP_BIND, CLS_REPORT, 1, CLS_IMM, 0, CLS_PRIM, 15));
      pending_items.push_back(make_instr(OP_ADD, CLS_REPORT, 0, CLS_PRIM, 1, CLS_IMM, 1));
      pending_items.push_back(make_instr(OP_ADD, CLS_REPORT, 0, CLS_IMM, 32'hFFFF_FFFF,
                                         CLS_IMM, 32'hFFFF_FFFF));
      pending_items.push_back(make_instr(OP_DIV, CLS_CONTROL, 15, CLS_PRIM, 1, CLS_IMM, 0));
      pending_items.push_back(make_instr(OP_DIV, CLS_CONTROL, 15, CLS_PRIM, 1, CLS_IMM, 7));
      pending_items.push_back(make_instr(OP_MUL, CLS_LOCAL, 3, CLS_PRIM, 1, CLS_IMM, 2));
      pending_items.push_back(make_instr(OP_MUL, CLS_LOCAL, 3, CLS_IMM, 32'hFFFF_FFFF,
                                         CLS_IMM, 32'hFFFF_FFFF));
      pending_items.push_back(make_instr(OP_SUB, CLS_TEMP, 2, CLS_IMM, 3, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_SUB, CLS_TEMP, 2, CLS_IMM, 9, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_EWMA, CLS_TEMP, 5, CLS_IMM, 8, CLS_IMM, 100));
      pending_items.push_back(make_instr(OP_EWMA, CLS_TEMP, 5, CLS_IMM, 8, CLS_IMM, 200));
      pending_items.push_back(make_instr(OP_MAXWRAP, CLS_IMPLICIT, 5, CLS_IMM, 32'hFFFF_FFF0,
                                         CLS_IMM, 5));
      pending_items.push_back(make_instr(OP_MAXWRAP, CLS_IMPLICIT, 6, CLS_IMM, 0, CLS_IMM, 5));
      pending_items.push_back(make_instr(OP_EQ, CLS_REPORT, 15, CLS_IMM, 5, CLS_IMPLICIT, 5));
      pending_items.push_back(make_instr(OP_GT, 3'd0, 0, CLS_IMM, 5, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_LT, 3'd7, 0, CLS_IMM, 5, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_MAX, CLS_LOCAL, 16, CLS_TEMP, 99, 3'd7, 2));
      pending_items.push_back(make_instr(OP_MIN, CLS_LOCAL, 0, CLS_IMM, 5, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_IF, CLS_LOCAL, 1, CLS_IMM, 0, CLS_IMM, 4));
      pending_items.push_back(make_instr(OP_NOTIF, CLS_LOCAL, 1, CLS_IMM, 0, CLS_IMM, 4));
      pending_items.push_back(make_instr(4'd14, CLS_LOCAL, 1, CLS_IMM, 1, CLS_IMM, 4));
      pending_items.push_back(make_instr(4'd15, CLS_LOCAL, 1, CLS_IMM, 1, CLS_IMM, 4));

      for (n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 60) begin
            while (pending_items.size() != 0) @(posedge clock);
            quiet_phase = 1'b1;
         end
         pending_items.push_back(random_item());
      end
      while (pending_items.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("** fold_instruction_executor_unit: PASSED **");
      end else begin
         $display("** fold_instruction_executor_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/fie_pkg.sv
sv/fie_ctrl.sv
sv/fie_dpath.sv
sv/fold_instruction_executor_unit.sv
tb/fold_instruction_executor_unit_tb.sv
